@@ rtl/mrah_pkg.sv @@
// Shared types and constants for the multi-rate average history block.
`timescale 1ns / 1ps
`default_nettype none
package mrah_pkg;

    localparam int NUM_RANGES = 3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] RANGE_SHORT = 2'd0;
    localparam logic [1:0] RANGE_MID   = 2'd1;
    localparam logic [1:0] RANGE_LONG  = 2'd2;

    localparam logic [1:0] REG_INTERVAL_SHORT = 2'd0;
    localparam logic [1:0] REG_INTERVAL_MID   = 2'd1;
    localparam logic [1:0] REG_INTERVAL_LONG  = 2'd2;

    localparam logic [15:0] SAMPLES_MAX = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       accum;
        logic       div_start;
        logic       wr_point;
        logic       rd_point;
        logic       load_out;
        logic [1:0] range;
    } mrah_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       cmd;
        logic [1:0] range_select;
        logic [2:0] due;
        logic       div_done;
    } mrah_stat_t;

endpackage
`default_nettype wire

@@ rtl/multi_rate_average_history.sv @@
// Top level: configuration registers, controller and datapath of the average history.
//
//  Channel  | Signals                                         | Direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid/in_ready, cmd, now_time, sample,       | in
//           | range_select, read_index                         |
//  output   | out_valid/out_ready, written_mask, point_time,  | out
//           | point_value, point_valid, stored_count          |
//  config   | psel, penable, pwrite, paddr, pwdata, prdata    | in/out
//
// A record passes through the accumulate and select steps, then through a division and a
// store write for each range whose interval has elapsed; the shared one-bit-per-cycle
// divider sets the pace of a record. A read passes through the read and read-wait states.
// One item is worked on at a time; the next is taken while a result waits in the
// output register. Reset clears all pointers, counts and accumulators; the point
// stores need no clearing since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
module multi_rate_average_history
    import mrah_pkg::*;
#(
    parameter int DEPTH_SHORT = 1024,
    parameter int DEPTH_MID   = 1024,
    parameter int DEPTH_LONG  = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [31:0]        now_time,
    input  wire logic signed [15:0] sample,
    input  wire logic [1:0]         range_select,
    input  wire logic [9:0]         read_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              written_mask,
    output logic [31:0]             point_time,
    output logic signed [15:0]      point_value,
    output logic                    point_valid,
    output logic [10:0]             stored_count
);

    logic [19:0] isht_reg, imid_reg, ilng_reg;
    logic        wr_en;
    mrah_cmd_t   ctl;
    mrah_stat_t  stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isht_reg <= 20'd60;
            imid_reg <= 20'd120;
            ilng_reg <= 20'd600;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_INTERVAL_SHORT: isht_reg <= pwdata[19:0];
                REG_INTERVAL_MID:   imid_reg <= pwdata[19:0];
                REG_INTERVAL_LONG:  ilng_reg <= pwdata[19:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INTERVAL_SHORT: prdata = {12'd0, isht_reg};
            REG_INTERVAL_MID:   prdata = {12'd0, imid_reg};
            REG_INTERVAL_LONG:  prdata = {12'd0, ilng_reg};
            default:            prdata = '0;
        endcase
    end

    mrah_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    mrah_datapath #(
        .DEPTH_SHORT (DEPTH_SHORT),
        .DEPTH_MID   (DEPTH_MID),
        .DEPTH_LONG  (DEPTH_LONG)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .interval_short (isht_reg),
        .interval_mid   (imid_reg),
        .interval_long  (ilng_reg),
        .cmd            (cmd),
        .now_time       (now_time),
        .sample         (sample),
        .range_select   (range_select),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .written_mask   (written_mask),
        .point_time     (point_time),
        .point_value    (point_value),
        .point_valid    (point_valid),
        .stored_count   (stored_count)
    );

endmodule
`default_nettype wire

@@ rtl/mrah_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrah_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/mrah_divider.sv @@
// Serial restoring divider: signed 32-bit dividend by positive 16-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module mrah_divider
    import mrah_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic [15:0]        divisor,
    output logic                    done,
    output logic [15:0]             quotient
);

    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? 32'(-dividend) : dividend;
            div_next  = divisor;
            neg_next  = dividend[31];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // Truncation toward zero: divide magnitudes, then restore the sign.
    assign done     = done_reg;
    assign quotient = neg_reg ? 16'(-quo_reg[15:0]) : quo_reg[15:0];

endmodule
`default_nettype wire

@@ rtl/mrah_datapath.sv @@
// Datapath: accumulators, ring-buffer pointers, point stores, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module mrah_datapath
    import mrah_pkg::*;
#(
    parameter int DEPTH_SHORT = 1024,
    parameter int DEPTH_MID   = 1024,
    parameter int DEPTH_LONG  = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mrah_cmd_t          ctl,
    output mrah_stat_t              stat,
    input  wire logic [19:0]        interval_short,
    input  wire logic [19:0]        interval_mid,
    input  wire logic [19:0]        interval_long,
    input  wire logic               cmd,
    input  wire logic [31:0]        now_time,
    input  wire logic signed [15:0] sample,
    input  wire logic [1:0]         range_select,
    input  wire logic [9:0]         read_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              written_mask,
    output logic [31:0]             point_time,
    output logic signed [15:0]      point_value,
    output logic                    point_valid,
    output logic [10:0]             stored_count
);

    localparam int DMAX = (DEPTH_SHORT > DEPTH_MID) ?
        ((DEPTH_SHORT > DEPTH_LONG) ? DEPTH_SHORT : DEPTH_LONG) :
        ((DEPTH_MID > DEPTH_LONG) ? DEPTH_MID : DEPTH_LONG);
    localparam int PW = $clog2(DMAX);
    localparam int CW = $clog2(DMAX + 1);
    localparam int SW = ((PW > 10) ? PW : 10) + 1;
    localparam int XW = ((CW > 10) ? CW : 10);
    localparam logic [CW-1:0] DEP [3] = '{CW'(DEPTH_SHORT), CW'(DEPTH_MID), CW'(DEPTH_LONG)};

    // Input item register.
    logic              cmd_reg;
    logic [31:0]       now_reg;
    logic signed [15:0] sample_reg;
    logic [1:0]        sel_reg;
    logic [9:0]        idx_reg;

    logic [PW-1:0]     pos_reg  [3];
    logic [CW-1:0]     fill_reg [3];
    logic [31:0]       last_reg [3];
    logic [31:0]       sum_reg  [3];
    logic [15:0]       cnt_reg  [3];
    logic [2:0]        due_reg;

    logic              ov_reg;
    logic [2:0]        mask_reg;
    logic [31:0]       ptime_reg;
    logic [15:0]       pval_reg;
    logic              pvalid_reg;
    logic [10:0]       scount_reg;

    logic [19:0]       intv [3];
    logic [1:0]        r;
    logic              div_done;
    logic [15:0]       quotient;
    logic [47:0]       rdata [3];
    logic [47:0]       rsel;
    logic [CW-1:0]     cur_fill;
    logic [PW-1:0]     cur_pos;
    logic [CW-1:0]     cur_dep;
    logic [PW-1:0]     start_pos;
    logic [SW-1:0]     ring_sum;
    logic [SW-1:0]     ring_wrap;
    logic [PW-1:0]     rd_addr;
    logic              idx_ok;
    logic [31:0]       fill32;

    assign intv[0] = interval_short;
    assign intv[1] = interval_mid;
    assign intv[2] = interval_long;
    assign r       = ctl.range;

    assign cur_fill  = (r == 2'd3) ? '0 : fill_reg[r];
    assign cur_pos   = (r == 2'd3) ? '0 : pos_reg[r];
    assign cur_dep   = (r == 2'd3) ? CW'(1) : DEP[r];
    assign start_pos = (cur_fill == cur_dep) ? cur_pos : '0;
    assign ring_sum  = SW'(start_pos) + SW'(idx_reg);
    assign ring_wrap = (ring_sum >= SW'(cur_dep)) ? ring_sum - SW'(cur_dep) : ring_sum;
    assign rd_addr   = ring_wrap[PW-1:0];
    assign idx_ok    = XW'(idx_reg) < XW'(cur_fill);
    assign fill32    = 32'(cur_fill);

    mrah_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend ((r == 2'd3) ? 32'sd0 : $signed(sum_reg[r])),
        .divisor  ((r == 2'd3) ? 16'd1 : cnt_reg[r]),
        .done     (div_done),
        .quotient (quotient)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_store
        localparam int DG = (g == 0) ? DEPTH_SHORT : ((g == 1) ? DEPTH_MID : DEPTH_LONG);
        localparam int AW = $clog2(DG);
        logic [PW-1:0] wa;
        assign wa = pos_reg[g];
        mrah_ram #(
            .WIDTH (48),
            .DEPTH (DG)
        ) u_ram (
            .clk   (clk),
            .we    (ctl.wr_point && (r == 2'(g))),
            .waddr (wa[AW-1:0]),
            .wdata ({now_reg, quotient}),
            .re    (ctl.rd_point && (r == 2'(g))),
            .raddr (rd_addr[AW-1:0]),
            .rdata (rdata[g])
        );
    end

    assign rsel = (sel_reg == 2'd0) ? rdata[0] : ((sel_reg == 2'd1) ? rdata[1] : rdata[2]);

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg    <= cmd;
            now_reg    <= now_time;
            sample_reg <= sample;
            sel_reg    <= range_select;
            idx_reg    <= read_index;
        end
        if (ctl.load_out)
        begin
            if (cmd_reg == CMD_RECORD)
            begin
                mask_reg   <= due_reg;
                ptime_reg  <= '0;
                pval_reg   <= '0;
                pvalid_reg <= 1'b0;
                scount_reg <= '0;
            end
            else
            begin
                // Range three reads as an empty range.
                mask_reg   <= '0;
                pvalid_reg <= idx_ok;
                ptime_reg  <= idx_ok ? rsel[47:16] : '0;
                pval_reg   <= idx_ok ? rsel[15:0] : '0;
                scount_reg <= fill32[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
                last_reg[i] <= '0;
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
            due_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.accum)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cnt_reg[i] != SAMPLES_MAX)
                    begin
                        sum_reg[i] <= sum_reg[i] + 32'(sample_reg);
                        cnt_reg[i] <= cnt_reg[i] + 16'd1;
                    end
                    due_reg[i] <= (now_reg - last_reg[i]) >= 32'(intv[i]);
                end
            end
            if (ctl.wr_point && (r != 2'd3))
            begin
                pos_reg[r]  <= (PW'(cur_pos) == PW'(cur_dep - CW'(1))) ? '0 : cur_pos + PW'(1);
                if (cur_fill < cur_dep)
                begin
                    fill_reg[r] <= cur_fill + CW'(1);
                end
                last_reg[r] <= now_reg;
                sum_reg[r]  <= '0;
                cnt_reg[r]  <= '0;
            end
            if (ctl.load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd          = cmd_reg;
    assign stat.range_select = sel_reg;
    assign stat.due          = due_reg;
    assign stat.div_done     = div_done;

    assign out_valid    = ov_reg;
    assign written_mask = mask_reg;
    assign point_time   = ptime_reg;
    assign point_value  = pval_reg;
    assign point_valid  = pvalid_reg;
    assign stored_count = scount_reg;

endmodule
`default_nettype wire

@@ rtl/mrah_ctrl.sv @@
// Controller: sequences accumulation, per-range averaging, store writes and reads.
`timescale 1ns / 1ps
`default_nettype none
module mrah_ctrl
    import mrah_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire mrah_stat_t stat,
    output mrah_cmd_t       ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SEL,
        S_DIV,
        S_WR,
        S_RD,
        S_RD_WAIT,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] range_reg, range_next;

    always_comb
    begin
        state_next = state_reg;
        range_next = range_reg;
        ctl        = '0;
        ctl.range  = range_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                if (stat.cmd == CMD_RECORD)
                begin
                    ctl.accum  = 1'b1;
                    range_next = RANGE_SHORT;
                    state_next = S_SEL;
                end
                else
                begin
                    range_next = stat.range_select;
                    state_next = S_RD;
                end
            end
            S_SEL:
            begin
                if (stat.due[range_reg])
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (range_reg == RANGE_LONG)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    range_next = range_reg + 2'd1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                ctl.wr_point = 1'b1;
                if (range_reg == RANGE_LONG)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    range_next = range_reg + 2'd1;
                    state_next = S_SEL;
                end
            end
            S_RD:
            begin
                ctl.rd_point = 1'b1;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // The result register takes the transfer once the last one has left.
                if (!out_valid || out_ready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            range_reg <= RANGE_SHORT;
        end
        else
        begin
            state_reg <= state_next;
            range_reg <= range_next;
        end
    end

endmodule
`default_nettype wire
